>>> rtl/core/sfsg_pkg.sv
`timescale 1ns / 1ps

package sfsg_pkg;

	localparam int COORD_BITS = 24;
	localparam int SEG_COUNT  = 30;
	localparam int SEG_IDX_W  = 5;
	localparam int HEIGHT_W   = 16;
	localparam int COLOR_W    = 24;
	localparam int MODE_W     = 2;
	localparam int UNIT_W     = 12;
	localparam int WIDTH_W    = 16;
	localparam int CODE_W     = 8;
	localparam int LEN_W      = 8;
	localparam int TERM_W     = 17;
	localparam int SUM_W      = 28;
	localparam int TEXT_W     = 27;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;

	// Division by 18 as a multiply by a rounded-up reciprocal; exact for
	// dividends below 2**21.
	localparam logic [17:0] RECIP_18    = 18'd233017;
	localparam int          RECIP_SHIFT = 22;

	localparam logic [UNIT_W-1:0]  UNIT_RESET  = 12'd256;
	localparam logic [WIDTH_W-1:0] WIDTH_RESET = 16'd512;
	localparam logic [COLOR_W-1:0] COLOR_RESET = 24'hFFFFFF;

	localparam logic [CFG_IDX_W-1:0] REG_GLYPH_HEIGHT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STROKE_COLOR  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ALIGN_MODE    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BASELINE_MODE = 2'd3;

	localparam logic [MODE_W-1:0] ALIGN_CENTER    = 2'd1;
	localparam logic [MODE_W-1:0] ALIGN_RIGHT     = 2'd2;
	localparam logic [MODE_W-1:0] BASELINE_MIDDLE = 2'd1;
	localparam logic [MODE_W-1:0] BASELINE_BOTTOM = 2'd2;

	localparam logic [CODE_W-1:0] CHAR_LOWER_A = 8'd97;
	localparam logic [CODE_W-1:0] CHAR_LOWER_Z = 8'd122;
	localparam logic [CODE_W-1:0] CASE_OFFSET  = 8'd32;

	localparam logic signed [SUM_W-1:0] COORD_MAX =
		SUM_W'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
	localparam logic signed [SUM_W-1:0] COORD_MIN = -COORD_MAX - SUM_W'(1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SETUP,
		ST_PLACE,
		ST_EMIT
	} sfsg_state_t;

	// Cell indices of a segment's endpoints; a coordinate is pen + (4*k+1)*unit.
	typedef struct packed {
		logic [2:0] sx;
		logic [2:0] sy;
		logic [2:0] ex;
		logic [2:0] ey;
	} seg_cell_t;

	function automatic seg_cell_t seg_cells(input logic [SEG_IDX_W-1:0] idx);
		seg_cell_t r;
		unique case (idx)
			5'd0:    r = '{3'd0, 3'd0, 3'd1, 3'd0};
			5'd1:    r = '{3'd1, 3'd0, 3'd2, 3'd0};
			5'd2:    r = '{3'd0, 3'd0, 3'd0, 3'd1};
			5'd3:    r = '{3'd0, 3'd1, 3'd1, 3'd0};
			5'd4:    r = '{3'd0, 3'd0, 3'd1, 3'd1};
			5'd5:    r = '{3'd1, 3'd0, 3'd1, 3'd1};
			5'd6:    r = '{3'd1, 3'd1, 3'd2, 3'd0};
			5'd7:    r = '{3'd1, 3'd0, 3'd2, 3'd1};
			5'd8:    r = '{3'd2, 3'd0, 3'd2, 3'd1};
			5'd9:    r = '{3'd0, 3'd1, 3'd0, 3'd2};
			5'd10:   r = '{3'd0, 3'd1, 3'd1, 3'd2};
			5'd11:   r = '{3'd1, 3'd1, 3'd1, 3'd2};
			5'd12:   r = '{3'd1, 3'd2, 3'd2, 3'd1};
			5'd13:   r = '{3'd2, 3'd1, 3'd2, 3'd2};
			5'd14:   r = '{3'd0, 3'd2, 3'd1, 3'd2};
			5'd15:   r = '{3'd1, 3'd2, 3'd2, 3'd2};
			5'd16:   r = '{3'd0, 3'd2, 3'd0, 3'd3};
			5'd17:   r = '{3'd0, 3'd3, 3'd1, 3'd2};
			5'd18:   r = '{3'd1, 3'd2, 3'd1, 3'd3};
			5'd19:   r = '{3'd1, 3'd2, 3'd2, 3'd3};
			5'd20:   r = '{3'd2, 3'd2, 3'd2, 3'd3};
			5'd21:   r = '{3'd0, 3'd3, 3'd0, 3'd4};
			5'd22:   r = '{3'd0, 3'd4, 3'd1, 3'd3};
			5'd23:   r = '{3'd0, 3'd3, 3'd1, 3'd4};
			5'd24:   r = '{3'd1, 3'd3, 3'd1, 3'd4};
			5'd25:   r = '{3'd1, 3'd4, 3'd2, 3'd3};
			5'd26:   r = '{3'd1, 3'd3, 3'd2, 3'd4};
			5'd27:   r = '{3'd2, 3'd3, 3'd2, 3'd4};
			5'd28:   r = '{3'd0, 3'd4, 3'd1, 3'd4};
			5'd29:   r = '{3'd1, 3'd4, 3'd2, 3'd4};
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic [SEG_COUNT-1:0] gb(input int n);
		return SEG_COUNT'(1) << n;
	endfunction

	// Glyph table; every code without an entry, including all codes above 127, is blank.
	function automatic logic [SEG_COUNT-1:0] glyph_bits(input logic [CODE_W-1:0] code);
		logic [SEG_COUNT-1:0] r;
		unique case (code)
			8'd33:   r = gb(5) | gb(11) | gb(24);
			8'd34:   r = gb(5) | gb(8);
			8'd39:   r = gb(5);
			8'd40:   r = gb(3) | gb(9) | gb(16) | gb(23);
			8'd41:   r = gb(7) | gb(13) | gb(20) | gb(25);
			8'd42:   r = gb(10) | gb(11) | gb(12) | gb(14) | gb(15) | gb(17) | gb(18)
				| gb(19);
			8'd44:   r = gb(22);
			8'd45:   r = gb(15) | gb(14);
			8'd46:   r = gb(22) | gb(23);
			8'd47:   r = gb(8) | gb(12) | gb(18) | gb(22);
			8'd48:   r = gb(3) | gb(7) | gb(9) | gb(12) | gb(13) | gb(16) | gb(17) | gb(20)
				| gb(23) | gb(25);
			8'd49:   r = gb(3) | gb(5) | gb(11) | gb(18) | gb(24) | gb(28) | gb(29);
			8'd50:   r = gb(3) | gb(1) | gb(8) | gb(13) | gb(15) | gb(17) | gb(21) | gb(28)
				| gb(29);
			8'd51:   r = gb(0) | gb(7) | gb(13) | gb(15) | gb(20) | gb(25) | gb(28);
			8'd52:   r = gb(3) | gb(9) | gb(14) | gb(15) | gb(11) | gb(18) | gb(24);
			8'd53:   r = gb(0) | gb(1) | gb(2) | gb(9) | gb(14) | gb(19) | gb(27) | gb(28)
				| gb(29);
			8'd54:   r = gb(0) | gb(1) | gb(2) | gb(9) | gb(14) | gb(19) | gb(27) | gb(28)
				| gb(29) | gb(16) | gb(21);
			8'd55:   r = gb(0) | gb(1) | gb(8) | gb(12) | gb(18) | gb(24);
			8'd56:   r = gb(0) | gb(1) | gb(2) | gb(8) | gb(9) | gb(13) | gb(14) | gb(15)
				| gb(16) | gb(20) | gb(21) | gb(27) | gb(28) | gb(29);
			8'd57:   r = gb(0) | gb(1) | gb(2) | gb(8) | gb(9) | gb(13) | gb(14) | gb(15)
				| gb(20) | gb(27) | gb(28) | gb(29);
			8'd58:   r = gb(24) | gb(11);
			8'd59:   r = gb(22) | gb(11);
			8'd63:   r = gb(2) | gb(1) | gb(0) | gb(8) | gb(12) | gb(24);
			8'd65:   r = gb(1) | gb(3) | gb(8) | gb(9) | gb(13) | gb(14) | gb(15) | gb(16)
				| gb(20) | gb(21) | gb(27);
			8'd66:   r = gb(0) | gb(2) | gb(7) | gb(9) | gb(12) | gb(14) | gb(16) | gb(19)
				| gb(21) | gb(27) | gb(28) | gb(29);
			8'd67:   r = gb(0) | gb(1) | gb(2) | gb(9) | gb(16) | gb(21) | gb(28) | gb(29);
			8'd68:   r = gb(0) | gb(2) | gb(7) | gb(9) | gb(13) | gb(16) | gb(20) | gb(21)
				| gb(25) | gb(28);
			8'd69:   r = gb(0) | gb(1) | gb(2) | gb(9) | gb(14) | gb(16) | gb(21) | gb(28)
				| gb(29);
			8'd70:   r = gb(0) | gb(1) | gb(2) | gb(9) | gb(14) | gb(16) | gb(21);
			8'd71:   r = gb(0) | gb(1) | gb(2) | gb(8) | gb(9) | gb(15) | gb(16) | gb(20)
				| gb(21) | gb(25) | gb(28);
			8'd72:   r = gb(2) | gb(8) | gb(9) | gb(13) | gb(14) | gb(15) | gb(16) | gb(20)
				| gb(21) | gb(27);
			8'd73:   r = gb(0) | gb(1) | gb(5) | gb(11) | gb(18) | gb(24) | gb(28) | gb(29);
			8'd74:   r = gb(1) | gb(8) | gb(13) | gb(20) | gb(21) | gb(25) | gb(28);
			8'd75:   r = gb(2) | gb(9) | gb(16) | gb(21) | gb(14) | gb(12) | gb(19) | gb(8)
				| gb(27);
			8'd76:   r = gb(2) | gb(9) | gb(16) | gb(21) | gb(28) | gb(29);
			8'd77:   r = gb(2) | gb(9) | gb(16) | gb(21) | gb(8) | gb(13) | gb(20) | gb(27)
				| gb(0) | gb(1) | gb(5) | gb(11);
			8'd78:   r = gb(2) | gb(9) | gb(16) | gb(21) | gb(0) | gb(7) | gb(13) | gb(20)
				| gb(27);
			8'd79:   r = gb(2) | gb(9) | gb(16) | gb(21) | gb(8) | gb(13) | gb(20) | gb(27)
				| gb(0) | gb(1) | gb(28) | gb(29);
			8'd80:   r = gb(2) | gb(9) | gb(16) | gb(21) | gb(0) | gb(14) | gb(7) | gb(12);
			8'd81:   r = gb(2) | gb(9) | gb(16) | gb(21) | gb(8) | gb(13) | gb(20) | gb(0)
				| gb(1) | gb(28) | gb(25) | gb(26);
			8'd82:   r = gb(2) | gb(9) | gb(16) | gb(21) | gb(0) | gb(14) | gb(7) | gb(13)
				| gb(15) | gb(19) | gb(27);
			8'd83:   r = gb(0) | gb(1) | gb(2) | gb(9) | gb(14) | gb(15) | gb(20) | gb(27)
				| gb(28) | gb(29);
			8'd84:   r = gb(0) | gb(1) | gb(5) | gb(11) | gb(18) | gb(24);
			8'd85:   r = gb(2) | gb(9) | gb(16) | gb(21) | gb(8) | gb(13) | gb(20) | gb(27)
				| gb(28) | gb(29);
			8'd86:   r = gb(2) | gb(9) | gb(16) | gb(21) | gb(8) | gb(13) | gb(20) | gb(25)
				| gb(28);
			8'd87:   r = gb(2) | gb(9) | gb(16) | gb(21) | gb(8) | gb(13) | gb(20) | gb(25)
				| gb(28) | gb(18) | gb(24);
			8'd88:   r = gb(2) | gb(21) | gb(10) | gb(17) | gb(12) | gb(19) | gb(8) | gb(27);
			8'd89:   r = gb(2) | gb(10) | gb(18) | gb(12) | gb(24) | gb(8);
			8'd90:   r = gb(0) | gb(1) | gb(8) | gb(12) | gb(17) | gb(21) | gb(28) | gb(29);
			8'd91:   r = gb(0) | gb(2) | gb(9) | gb(16) | gb(21) | gb(28);
			8'd93:   r = gb(1) | gb(8) | gb(13) | gb(20) | gb(27) | gb(29);
			8'd95:   r = gb(28) | gb(29);
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic signed [COORD_BITS-1:0] sat_coord(
		input logic signed [SUM_W-1:0] v
	);
		logic signed [COORD_BITS-1:0] r;
		if (v > COORD_MAX) begin
			r = COORD_MAX[COORD_BITS-1:0];
		end else if (v < COORD_MIN) begin
			r = COORD_MIN[COORD_BITS-1:0];
		end else begin
			r = v[COORD_BITS-1:0];
		end
		return r;
	endfunction

endpackage

>>> rtl/core/stroke_font_segment_generator_unit.sv
`timescale 1ns / 1ps

// Stroke font segment generator.
// Input channel s_*: one item per character. tuser flags the first character of
// a string, which also carries the anchor point and the string length. Output
// channel m_*: one item per line segment of the character's glyph, in segment
// order; tlast marks the last segment of a character. Blank characters give no
// output item but still advance the pen.
// Configuration: cfg_we writes cfg_wdata into register cfg_index (0 glyph
// height, 1 stroke color, 2 alignment mode, 3 baseline mode). Write only while
// idle. The height is converted to the glyph unit and stroke width on write.
// Timing: an accepted item passes the states ST_SETUP and ST_PLACE; the first
// segment is loaded into the output register in ST_EMIT, then one segment per
// cycle while the receiver is ready. A combinational priority encoder finds the
// lowest set glyph bit. The glyph table is read synchronously in the cycle after
// acceptance while the anchor placement product is formed.
// A stalled receiver holds the output register and the segment loop waits; the
// next character is accepted as soon as its predecessor's last segment has been
// loaded into the output register.
// Reset clears the pen to zero and loads the register defaults (height 18.0,
// white, left, top).

module stroke_font_segment_generator_unit
	import sfsg_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// char_code [7:0], anchor_x [31:8], anchor_y [55:32], string_length [63:56]
	input  logic [63:0]           s_tdata,
	// string_start [0]
	input  logic                  s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// seg_start_x [23:0], seg_start_y [47:24], seg_end_x [71:48],
	// seg_end_y [95:72], stroke_width [111:96], seg_color [135:112]
	output logic [135:0]          m_tdata,
	output logic                  m_tlast
);

	sfsg_state_t state_q, state_d;

	logic [UNIT_W-1:0]  unit_q;
	logic [WIDTH_W-1:0] width_q;
	logic [COLOR_W-1:0] color_q;
	logic [MODE_W-1:0]  align_q;
	logic [MODE_W-1:0]  baseline_q;

	logic signed [COORD_BITS-1:0] pen_x_q, pen_y_q;

	logic                         start_q;
	logic signed [COORD_BITS-1:0] anchor_x_q, anchor_y_q;
	logic [LEN_W-1:0]             len_q;
	logic signed [TEXT_W-1:0]     text_len_s1;
	logic [SEG_COUNT-1:0]         mask_q;

	logic                         out_valid_q;
	logic signed [COORD_BITS-1:0] out_sx_q, out_sy_q, out_ex_q, out_ey_q;
	logic [WIDTH_W-1:0]           out_width_q;
	logic [COLOR_W-1:0]           out_color_q;
	logic                         out_last_q;

	logic                 accept;
	logic                 load_seg;
	logic                 finish;
	logic                 out_free;
	logic [CODE_W-1:0]    in_code;
	logic [CODE_W-1:0]    code_up;
	logic [SEG_COUNT-1:0] rom_data;
	logic [SEG_IDX_W-1:0] seg_idx;
	logic [SEG_COUNT-1:0] mask_rest;
	seg_cell_t            cells;

	// Height to unit and width: (h + 9) / 18 and (2h + 9) / 18.
	logic [16:0] h_plus;
	logic [17:0] h2_plus;
	logic [34:0] unit_prod;
	logic [35:0] width_prod;

	assign h_plus     = {1'b0, cfg_wdata[HEIGHT_W-1:0]} + 17'd9;
	assign h2_plus    = {1'b0, cfg_wdata[HEIGHT_W-1:0], 1'b0} + 18'd9;
	assign unit_prod  = h_plus * RECIP_18;
	assign width_prod = h2_plus * RECIP_18;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_q     <= UNIT_RESET;
			width_q    <= WIDTH_RESET;
			color_q    <= COLOR_RESET;
			align_q    <= '0;
			baseline_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GLYPH_HEIGHT: begin
					unit_q  <= UNIT_W'(unit_prod >> RECIP_SHIFT);
					width_q <= WIDTH_W'(width_prod >> RECIP_SHIFT);
				end
				REG_STROKE_COLOR:  color_q    <= cfg_wdata[COLOR_W-1:0];
				REG_ALIGN_MODE:    align_q    <= cfg_wdata[MODE_W-1:0];
				REG_BASELINE_MODE: baseline_q <= cfg_wdata[MODE_W-1:0];
				default: ;
			endcase
		end
	end

	assign in_code = s_tdata[7:0];
	assign code_up = (in_code >= CHAR_LOWER_A && in_code <= CHAR_LOWER_Z)
		? in_code - CASE_OFFSET : in_code;

	sfsg_glyph_rom u_rom (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (code_up),
		.rd_data (rom_data)
	);

	// Lowest set bit of the remaining glyph mask.
	always_comb begin
		seg_idx = '0;
		for (int i = SEG_COUNT - 1; i >= 0; i--) begin
			if (mask_q[i]) begin
				seg_idx = SEG_IDX_W'(i);
			end
		end
	end

	assign mask_rest = mask_q & (mask_q - SEG_COUNT'(1));
	assign cells     = seg_cells(seg_idx);
	assign out_free  = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		accept   = 1'b0;
		load_seg = 1'b0;
		finish   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				accept   = s_tvalid;
				if (s_tvalid) begin
					state_d = ST_SETUP;
				end
			end
			ST_SETUP: state_d = ST_PLACE;
			ST_PLACE: state_d = ST_EMIT;
			ST_EMIT: begin
				if (mask_q == '0) begin
					finish  = 1'b1;
					state_d = ST_IDLE;
				end else if (out_free) begin
					load_seg = 1'b1;
					if (mask_rest == '0) begin
						finish  = 1'b1;
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Capture the item.
	always_ff @(posedge clk) begin
		if (accept) begin
			start_q    <= s_tuser;
			anchor_x_q <= s_tdata[31:8];
			anchor_y_q <= s_tdata[55:32];
			len_q      <= s_tdata[63:56];
		end
	end

	// Text length (11*len - 1)*unit, formed while the glyph table is read.
	logic [12:0]        len11;
	logic signed [13:0] len_m1;

	assign len11  = {2'b00, len_q, 3'b000} + {4'b0000, len_q, 1'b0} + {5'b00000, len_q};
	assign len_m1 = $signed({1'b0, len11}) - 14'sd1;

	always_ff @(posedge clk) begin
		if (state_q == ST_SETUP) begin
			text_len_s1 <= TEXT_W'(len_m1) * TEXT_W'($signed({1'b0, unit_q}));
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SETUP) begin
			mask_q <= rom_data;
		end else if (load_seg) begin
			mask_q <= mask_rest;
		end
	end

	// Pen placement and advance.
	logic signed [TEXT_W-1:0] x_adj;
	logic [16:0]              y_off;
	logic [15:0]              unit9;
	logic [15:0]              unit11;
	logic signed [SUM_W-1:0]  place_x, place_y, advance_x;

	assign unit9  = {1'b0, unit_q, 3'b000} + {4'b0000, unit_q};
	assign unit11 = unit9 + {3'b000, unit_q, 1'b0};

	always_comb begin
		if (align_q == ALIGN_CENTER) begin
			x_adj = text_len_s1 >>> 1;
		end else if (align_q == ALIGN_RIGHT) begin
			x_adj = text_len_s1;
		end else begin
			x_adj = '0;
		end
		if (baseline_q == BASELINE_MIDDLE) begin
			y_off = {1'b0, unit9};
		end else if (baseline_q == BASELINE_BOTTOM) begin
			y_off = {unit9, 1'b0};
		end else begin
			y_off = '0;
		end
	end

	assign place_x   = SUM_W'(anchor_x_q) - SUM_W'(x_adj);
	assign place_y   = SUM_W'(anchor_y_q) - SUM_W'(y_off);
	assign advance_x = SUM_W'(pen_x_q) + SUM_W'(unit11);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pen_x_q <= '0;
			pen_y_q <= '0;
		end else if (state_q == ST_PLACE && start_q) begin
			pen_x_q <= sat_coord(place_x);
			pen_y_q <= sat_coord(place_y);
		end else if (finish) begin
			pen_x_q <= sat_coord(advance_x);
		end
	end

	// Endpoint offsets (4*k + 1)*unit.
	function automatic logic [TERM_W-1:0] cell_term(
		input logic [2:0]        k,
		input logic [UNIT_W-1:0] u
	);
		return TERM_W'({k, 2'b01}) * TERM_W'(u);
	endfunction

	logic signed [SUM_W-1:0] sx_sum, sy_sum, ex_sum, ey_sum;

	assign sx_sum = SUM_W'(pen_x_q) + SUM_W'(cell_term(cells.sx, unit_q));
	assign sy_sum = SUM_W'(pen_y_q) + SUM_W'(cell_term(cells.sy, unit_q));
	assign ex_sum = SUM_W'(pen_x_q) + SUM_W'(cell_term(cells.ex, unit_q));
	assign ey_sum = SUM_W'(pen_y_q) + SUM_W'(cell_term(cells.ey, unit_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_seg) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_seg) begin
			out_sx_q    <= sat_coord(sx_sum);
			out_sy_q    <= sat_coord(sy_sum);
			out_ex_q    <= sat_coord(ex_sum);
			out_ey_q    <= sat_coord(ey_sum);
			out_width_q <= width_q;
			out_color_q <= color_q;
			out_last_q  <= (mask_rest == '0);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_color_q, out_width_q, out_ey_q, out_ex_q, out_sy_q, out_sx_q};
	assign m_tlast  = out_last_q;

endmodule

>>> rtl/core/sfsg_glyph_rom.sv
`timescale 1ns / 1ps

module sfsg_glyph_rom
	import sfsg_pkg::*;
(
	input  logic                 clk,
	input  logic                 rd_en,
	input  logic [CODE_W-1:0]    rd_addr,
	output logic [SEG_COUNT-1:0] rd_data
);

	logic [SEG_COUNT-1:0] rd_data_q;

	// Synchronous read: data for an address appears the cycle after rd_en.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= glyph_bits(rd_addr);
		end
	end

	assign rd_data = rd_data_q;

endmodule
